// ===== rtl/mpenc_pkg.sv =====
// ----------------------------------------------------------------------------
// mpenc_pkg
// Types and constants shared by the MessagePack token encoder modules.
// ----------------------------------------------------------------------------
package mpenc_pkg;

    typedef enum logic [3:0] {
        FN_NIL   = 4'd0,
        FN_BOOL  = 4'd1,
        FN_UINT  = 4'd2,
        FN_INT   = 4'd3,
        FN_F32   = 4'd4,
        FN_F64   = 4'd5,
        FN_STR   = 4'd6,
        FN_BIN   = 4'd7,
        FN_ARRAY = 4'd8,
        FN_MAP   = 4'd9,
        FN_EXT   = 4'd10,
        FN_RAW   = 4'd11
    } func_t;

    localparam logic [7:0] TAG_NIL      = 8'hC0;
    localparam logic [7:0] TAG_FALSE    = 8'hC2;
    localparam logic [7:0] TAG_TRUE     = 8'hC3;
    localparam logic [7:0] TAG_BIN8     = 8'hC4;
    localparam logic [7:0] TAG_BIN16    = 8'hC5;
    localparam logic [7:0] TAG_BIN32    = 8'hC6;
    localparam logic [7:0] TAG_EXT8     = 8'hC7;
    localparam logic [7:0] TAG_EXT16    = 8'hC8;
    localparam logic [7:0] TAG_EXT32    = 8'hC9;
    localparam logic [7:0] TAG_F32      = 8'hCA;
    localparam logic [7:0] TAG_F64      = 8'hCB;
    localparam logic [7:0] TAG_UINT8    = 8'hCC;
    localparam logic [7:0] TAG_UINT16   = 8'hCD;
    localparam logic [7:0] TAG_UINT32   = 8'hCE;
    localparam logic [7:0] TAG_UINT64   = 8'hCF;
    localparam logic [7:0] TAG_INT8     = 8'hD0;
    localparam logic [7:0] TAG_INT16    = 8'hD1;
    localparam logic [7:0] TAG_INT32    = 8'hD2;
    localparam logic [7:0] TAG_INT64    = 8'hD3;
    localparam logic [7:0] TAG_FIXEXT1  = 8'hD4;
    localparam logic [7:0] TAG_STR8     = 8'hD9;
    localparam logic [7:0] TAG_STR16    = 8'hDA;
    localparam logic [7:0] TAG_STR32    = 8'hDB;
    localparam logic [7:0] TAG_ARRAY16  = 8'hDC;
    localparam logic [7:0] TAG_ARRAY32  = 8'hDD;
    localparam logic [7:0] TAG_MAP16    = 8'hDE;
    localparam logic [7:0] TAG_MAP32    = 8'hDF;
    localparam logic [7:0] TAG_FIXSTR   = 8'hA0;
    localparam logic [7:0] TAG_FIXARRAY = 8'h90;
    localparam logic [7:0] TAG_FIXMAP   = 8'h80;

    localparam int unsigned MAX_BYTES = 9;

    // Encoded token: bytes in send order, byte count (1..9), error flag
    typedef struct packed {
        logic [0:MAX_BYTES-1][7:0] bytes;
        logic [3:0]                count;
        logic                      err;
    } tok_t;

endpackage

// ===== rtl/msgpack_token_encoder_top.sv =====
// The strobe for the first byte of a token rises once start is taken into an
// empty queue and the queue count, then the strobe register, have been loaded.
// The serialiser sends one byte per cycle while the queue holds a token, and
// busy rises while two tokens are queued.
// Reset clears the queue, the byte index and the strobe; the receiver cannot
// stall, so a transfer takes place in every strobed cycle.
// ----------------------------------------------------------------------------
// msgpack_token_encoder_top
// MessagePack token encoder: classifier, token queue and byte serialiser.
// ----------------------------------------------------------------------------
module msgpack_token_encoder_top
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [3:0]         func,
    input  logic [63:0]        value,
    input  logic signed [7:0]  ext_type,
    output logic               strobe,
    output logic [7:0]         out_byte,
    output logic               last,
    output logic               error
);

    mpenc_pkg::tok_t wr_tok;
    mpenc_pkg::tok_t rd_tok;
    logic            push;
    logic            pop;
    logic            empty;
    logic            full;

    assign busy = full;

    mpenc_front u_front
    (
        .start    (start),
        .full     (full),
        .func     (func),
        .value    (value),
        .ext_type (ext_type),
        .push     (push),
        .tok      (wr_tok)
    );

    mpenc_queue u_queue
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .wr_tok   (wr_tok),
        .pop      (pop),
        .rd_tok   (rd_tok),
        .empty    (empty),
        .full     (full)
    );

    mpenc_back u_back
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .head     (rd_tok),
        .empty    (empty),
        .pop      (pop),
        .strobe   (strobe),
        .out_byte (out_byte),
        .last     (last),
        .error    (error)
    );

endmodule

// ===== rtl/mpenc_front.sv =====
// ----------------------------------------------------------------------------
// mpenc_front
// Accepts a token and classifies it into its encoded byte string.
// ----------------------------------------------------------------------------
module mpenc_front
(
    input  logic               start,
    input  logic               full,
    input  logic [3:0]         func,
    input  logic [63:0]        value,
    input  logic signed [7:0]  ext_type,
    output logic               push,
    output mpenc_pkg::tok_t    tok
);

    logic [7:0]  tag;
    logic [3:0]  plen;
    logic        trailer;
    logic        err;
    logic [31:0] len;
    logic        neg;
    logic [63:0] pl;
    logic [3:0]  tidx;

    assign push = start & ~full;
    assign len  = value[31:0];
    assign neg  = value[63];

    always_comb
    begin
        tag     = 8'h00;
        plen    = 4'd0;
        trailer = 1'b0;
        err     = 1'b0;
        unique case (mpenc_pkg::func_t'(func))
            mpenc_pkg::FN_NIL:   tag = mpenc_pkg::TAG_NIL;
            mpenc_pkg::FN_BOOL:  tag = value[0] ? mpenc_pkg::TAG_TRUE : mpenc_pkg::TAG_FALSE;
            mpenc_pkg::FN_UINT:
            begin
                if (~|value[63:7])
                    tag = value[7:0];
                else if (~|value[63:8])
                begin
                    tag = mpenc_pkg::TAG_UINT8;  plen = 4'd1;
                end
                else if (~|value[63:16])
                begin
                    tag = mpenc_pkg::TAG_UINT16; plen = 4'd2;
                end
                else if (~|value[63:32])
                begin
                    tag = mpenc_pkg::TAG_UINT32; plen = 4'd4;
                end
                else
                begin
                    tag = mpenc_pkg::TAG_UINT64; plen = 4'd8;
                end
            end
            mpenc_pkg::FN_INT:
            begin
                if ((~neg & ~|value[63:7]) | (&value[63:5]))
                    tag = value[7:0];
                else if (neg & &value[63:7])
                begin
                    tag = mpenc_pkg::TAG_INT8;  plen = 4'd1;
                end
                else if (neg & &value[63:15])
                begin
                    tag = mpenc_pkg::TAG_INT16; plen = 4'd2;
                end
                else if (neg & &value[63:31])
                begin
                    tag = mpenc_pkg::TAG_INT32; plen = 4'd4;
                end
                else
                begin
                    tag = mpenc_pkg::TAG_INT64; plen = 4'd8;
                end
            end
            mpenc_pkg::FN_F32:
            begin
                tag = mpenc_pkg::TAG_F32; plen = 4'd4;
            end
            mpenc_pkg::FN_F64:
            begin
                tag = mpenc_pkg::TAG_F64; plen = 4'd8;
            end
            mpenc_pkg::FN_STR:
            begin
                if (len <= 32'd31)
                    tag = mpenc_pkg::TAG_FIXSTR | {3'b000, len[4:0]};
                else if (len <= 32'd255)
                begin
                    tag = mpenc_pkg::TAG_STR8;  plen = 4'd1;
                end
                else if (len <= 32'd65535)
                begin
                    tag = mpenc_pkg::TAG_STR16; plen = 4'd2;
                end
                else
                begin
                    tag = mpenc_pkg::TAG_STR32; plen = 4'd4;
                end
            end
            mpenc_pkg::FN_BIN:
            begin
                if (len <= 32'd255)
                begin
                    tag = mpenc_pkg::TAG_BIN8;  plen = 4'd1;
                end
                else if (len <= 32'd65535)
                begin
                    tag = mpenc_pkg::TAG_BIN16; plen = 4'd2;
                end
                else
                begin
                    tag = mpenc_pkg::TAG_BIN32; plen = 4'd4;
                end
            end
            mpenc_pkg::FN_ARRAY:
            begin
                if (len <= 32'd15)
                    tag = mpenc_pkg::TAG_FIXARRAY | {4'h0, len[3:0]};
                else if (len <= 32'd65535)
                begin
                    tag = mpenc_pkg::TAG_ARRAY16; plen = 4'd2;
                end
                else
                begin
                    tag = mpenc_pkg::TAG_ARRAY32; plen = 4'd4;
                end
            end
            mpenc_pkg::FN_MAP:
            begin
                if (len <= 32'd15)
                    tag = mpenc_pkg::TAG_FIXMAP | {4'h0, len[3:0]};
                else if (len <= 32'd65535)
                begin
                    tag = mpenc_pkg::TAG_MAP16; plen = 4'd2;
                end
                else
                begin
                    tag = mpenc_pkg::TAG_MAP32; plen = 4'd4;
                end
            end
            mpenc_pkg::FN_EXT:
            begin
                trailer = 1'b1;
                if (len == 32'd1)
                    tag = mpenc_pkg::TAG_FIXEXT1;
                else if (len == 32'd2)
                    tag = mpenc_pkg::TAG_FIXEXT1 + 8'd1;
                else if (len == 32'd4)
                    tag = mpenc_pkg::TAG_FIXEXT1 + 8'd2;
                else if (len == 32'd8)
                    tag = mpenc_pkg::TAG_FIXEXT1 + 8'd3;
                else if (len == 32'd16)
                    tag = mpenc_pkg::TAG_FIXEXT1 + 8'd4;
                else if (len <= 32'd255)
                begin
                    tag = mpenc_pkg::TAG_EXT8;  plen = 4'd1;
                end
                else if (len <= 32'd65535)
                begin
                    tag = mpenc_pkg::TAG_EXT16; plen = 4'd2;
                end
                else
                begin
                    tag = mpenc_pkg::TAG_EXT32; plen = 4'd4;
                end
            end
            mpenc_pkg::FN_RAW:   tag = value[7:0];
            default:             err = 1'b1;
        endcase
    end

    // payload left-aligned, most significant byte first
    always_comb
    begin
        case (plen)
            4'd1:    pl = {value[7:0], 56'h0};
            4'd2:    pl = {value[15:0], 48'h0};
            4'd4:    pl = {value[31:0], 32'h0};
            4'd8:    pl = value;
            default: pl = 64'h0;
        endcase
    end

    assign tidx = plen + 4'd1;

    always_comb
    begin
        tok.bytes = {tag, pl};
        if (trailer)
            tok.bytes[tidx] = ext_type;
        tok.count = 4'd1 + plen + {3'b000, trailer};
        tok.err   = err;
    end

endmodule

// ===== rtl/mpenc_queue.sv =====
// ----------------------------------------------------------------------------
// mpenc_queue
// Two-entry token queue between the front and back ends.
// ----------------------------------------------------------------------------
module mpenc_queue
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  mpenc_pkg::tok_t    wr_tok,
    input  logic               pop,
    output mpenc_pkg::tok_t    rd_tok,
    output logic               empty,
    output logic               full
);

    mpenc_pkg::tok_t ent_reg [2];
    logic            wr_ptr_reg;
    logic            wr_ptr_next;
    logic            rd_ptr_reg;
    logic            rd_ptr_next;
    logic [1:0]      cnt_reg;
    logic [1:0]      cnt_next;

    assign empty  = (cnt_reg == 2'd0);
    assign full   = (cnt_reg == 2'd2);
    assign rd_tok = ent_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg ^ push;
        rd_ptr_next = rd_ptr_reg ^ pop;
        cnt_next    = cnt_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            ent_reg[wr_ptr_reg] <= wr_tok;
    end

    a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !(pop && empty))
        else $error("pop from empty queue");

    a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
        !(push && full))
        else $error("push into full queue");

    a_ptr_track: assert property (@(posedge clk) disable iff (!rst_n)
        (cnt_reg == 2'd1) |-> (wr_ptr_reg != rd_ptr_reg))
        else $error("queue pointers out of step");

endmodule

// ===== rtl/mpenc_back.sv =====
// ----------------------------------------------------------------------------
// mpenc_back
// Serialises the token at the queue head, one byte per cycle while the queue holds a token.
// ----------------------------------------------------------------------------
module mpenc_back
(
    input  logic               clk,
    input  logic               rst_n,
    input  mpenc_pkg::tok_t    head,
    input  logic               empty,
    output logic               pop,
    output logic               strobe,
    output logic [7:0]         out_byte,
    output logic               last,
    output logic               error
);

    logic [3:0] idx_reg;
    logic [3:0] idx_next;
    logic       at_last;
    logic       strobe_reg;
    logic [7:0] byte_reg;
    logic       last_reg;
    logic       err_reg;

    assign at_last = (idx_reg == head.count - 4'd1);
    assign pop     = ~empty & at_last;

    always_comb
    begin
        idx_next = idx_reg;
        if (!empty)
            idx_next = at_last ? 4'd0 : idx_reg + 4'd1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg    <= 4'd0;
            strobe_reg <= 1'b0;
        end
        else
        begin
            idx_reg    <= idx_next;
            strobe_reg <= ~empty;
        end
    end

    always_ff @(posedge clk)
    begin
        byte_reg <= head.bytes[idx_reg];
        last_reg <= at_last;
        err_reg  <= head.err;
    end

    assign strobe   = strobe_reg;
    assign out_byte = byte_reg;
    assign last     = last_reg;
    assign error    = err_reg;

    a_err_single: assert property (@(posedge clk) disable iff (!rst_n)
        (strobe && error) |-> last)
        else $error("error transfer without last");

    a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> (idx_reg < head.count))
        else $error("byte index beyond token");

    a_token_burst: assert property (@(posedge clk) disable iff (!rst_n)
        (strobe && !last) |=> strobe)
        else $error("gap inside a token");

endmodule

// ===== verif/tb_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the MessagePack token encoder. Tokens go in through
// the start/busy command port; a scoreboard encodes each accepted token with
// its own encoder and compares every strobed byte, its last mark and its error
// flag in order.
// ----------------------------------------------------------------------------
module tb_top;

    localparam logic [3:0] FN_UNUSED_LO = 4'd12;
    localparam logic [3:0] FN_UNUSED_HI = 4'd15;
    localparam int         RANDOM_TOKENS = 194;
    localparam int         QUIET_TOKENS  = 70;

    localparam logic [63:0] EDGE_VALUES [20] = '{
        64'd0, 64'd15, 64'd16, 64'd31, 64'd32, 64'd127, 64'd128, 64'd255, 64'd256,
        64'd65535, 64'd65536, 64'hFFFF_FFFF, 64'h1_0000_0000,
        64'hFFFF_FFFF_FFFF_FFE0, 64'hFFFF_FFFF_FFFF_FF80, 64'hFFFF_FFFF_FFFF_8000,
        64'hFFFF_FFFF_8000_0000, 64'h8000_0000_0000_0000, 64'h7FFF_FFFF_FFFF_FFFF,
        64'hFFFF_FFFF_FFFF_FFFF
    };

    class token_scoreboard;
        typedef struct {
            logic [7:0] data;
            logic       last;
            logic       err;
        } enc_byte_t;

        enc_byte_t   pending[$];
        logic [7:0]  work[$];
        int unsigned tokens;
        int unsigned err_tokens;
        int unsigned bytes_seen;
        int unsigned mismatches;

        function void put_be(logic [63:0] v, int n);
            for (int i = n - 1; i >= 0; i--)
                work.push_back(v[8*i +: 8]);
        endfunction

        function void put_len(logic [31:0] len, int fix_max, logic [7:0] fix_tag, bit has8,
                              logic [7:0] tag8, logic [7:0] tag16, logic [7:0] tag32);
            if (fix_max > 0 && len <= fix_max)
                work.push_back(fix_tag | len[7:0]);
            else if (has8 && len <= 32'd255)
            begin
                work.push_back(tag8);
                put_be(len, 1);
            end
            else if (len <= 32'd65535)
            begin
                work.push_back(tag16);
                put_be(len, 2);
            end
            else
            begin
                work.push_back(tag32);
                put_be(len, 4);
            end
        endfunction

        function void note_token(logic [3:0] f, logic [63:0] v, logic [7:0] t);
            logic signed [63:0] sv;
            logic [31:0]        len;
            sv = v;
            len = v[31:0];
            work.delete();
            tokens++;
            case (f)
                mpenc_pkg::FN_NIL:  work.push_back(mpenc_pkg::TAG_NIL);
                mpenc_pkg::FN_BOOL:
                    work.push_back(v[0] ? mpenc_pkg::TAG_TRUE : mpenc_pkg::TAG_FALSE);
                mpenc_pkg::FN_UINT:
                begin
                    if (v <= 64'd127)
                        put_be(v, 1);
                    else if (v <= 64'd255)
                    begin
                        work.push_back(mpenc_pkg::TAG_UINT8);
                        put_be(v, 1);
                    end
                    else if (v <= 64'd65535)
                    begin
                        work.push_back(mpenc_pkg::TAG_UINT16);
                        put_be(v, 2);
                    end
                    else if (v <= 64'hFFFF_FFFF)
                    begin
                        work.push_back(mpenc_pkg::TAG_UINT32);
                        put_be(v, 4);
                    end
                    else
                    begin
                        work.push_back(mpenc_pkg::TAG_UINT64);
                        put_be(v, 8);
                    end
                end
                mpenc_pkg::FN_INT:
                begin
                    if (sv >= -32 && sv <= 127)
                        put_be(v, 1);
                    else if (sv >= -128 && sv < 0)
                    begin
                        work.push_back(mpenc_pkg::TAG_INT8);
                        put_be(v, 1);
                    end
                    else if (sv >= -32768 && sv < 0)
                    begin
                        work.push_back(mpenc_pkg::TAG_INT16);
                        put_be(v, 2);
                    end
                    else if (sv >= -64'sd2147483648 && sv < 0)
                    begin
                        work.push_back(mpenc_pkg::TAG_INT32);
                        put_be(v, 4);
                    end
                    else
                    begin
                        // positive values above 127 also land here
                        work.push_back(mpenc_pkg::TAG_INT64);
                        put_be(v, 8);
                    end
                end
                mpenc_pkg::FN_F32:
                begin
                    work.push_back(mpenc_pkg::TAG_F32);
                    put_be(v[31:0], 4);
                end
                mpenc_pkg::FN_F64:
                begin
                    work.push_back(mpenc_pkg::TAG_F64);
                    put_be(v, 8);
                end
                mpenc_pkg::FN_STR:
                    put_len(len, 31, mpenc_pkg::TAG_FIXSTR, 1'b1, mpenc_pkg::TAG_STR8,
                            mpenc_pkg::TAG_STR16, mpenc_pkg::TAG_STR32);
                mpenc_pkg::FN_BIN:
                    put_len(len, 0, 8'h00, 1'b1, mpenc_pkg::TAG_BIN8,
                            mpenc_pkg::TAG_BIN16, mpenc_pkg::TAG_BIN32);
                mpenc_pkg::FN_ARRAY:
                    put_len(len, 15, mpenc_pkg::TAG_FIXARRAY, 1'b0, 8'h00,
                            mpenc_pkg::TAG_ARRAY16, mpenc_pkg::TAG_ARRAY32);
                mpenc_pkg::FN_MAP:
                    put_len(len, 15, mpenc_pkg::TAG_FIXMAP, 1'b0, 8'h00,
                            mpenc_pkg::TAG_MAP16, mpenc_pkg::TAG_MAP32);
                mpenc_pkg::FN_EXT:
                begin
                    case (len)
                        32'd1:   work.push_back(mpenc_pkg::TAG_FIXEXT1);
                        32'd2:   work.push_back(mpenc_pkg::TAG_FIXEXT1 + 8'd1);
                        32'd4:   work.push_back(mpenc_pkg::TAG_FIXEXT1 + 8'd2);
                        32'd8:   work.push_back(mpenc_pkg::TAG_FIXEXT1 + 8'd3);
                        32'd16:  work.push_back(mpenc_pkg::TAG_FIXEXT1 + 8'd4);
                        default: put_len(len, 0, 8'h00, 1'b1, mpenc_pkg::TAG_EXT8,
                                         mpenc_pkg::TAG_EXT16, mpenc_pkg::TAG_EXT32);
                    endcase
                    work.push_back(t);
                end
                mpenc_pkg::FN_RAW:   work.push_back(v[7:0]);
                default:
                begin
                    err_tokens++;
                    pending.push_back('{8'h00, 1'b1, 1'b1});
                    return;
                end
            endcase
            foreach (work[i])
                pending.push_back('{work[i], i == work.size() - 1, 1'b0});
        endfunction

        function void flag(string what, enc_byte_t want, logic [7:0] d, logic l, logic e);
            mismatches++;
            if (mismatches <= 10)
                $display("[%0t] %s: expected byte %02h last %b err %b, got %02h %b %b",
                         $realtime, what, want.data, want.last, want.err, d, l, e);
        endfunction

        function void check_byte(logic [7:0] d, logic l, logic e);
            enc_byte_t want;
            bytes_seen++;
            if (pending.size() == 0)
            begin
                want = '{8'hxx, 1'bx, 1'bx};
                flag("unexpected transfer", want, d, l, e);
                return;
            end
            want = pending.pop_front();
            if (d !== want.data || l !== want.last || e !== want.err)
                flag("byte mismatch", want, d, l, e);
        endfunction
    endclass

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               start = 1'b0;
    logic               busy;
    logic [3:0]         func = 4'd0;
    logic [63:0]        value = 64'd0;
    logic signed [7:0]  ext_type = 8'sd0;
    logic               strobe;
    logic [7:0]         out_byte;
    logic               last;
    logic               error;

    bit                 idle_on = 1'b1;
    token_scoreboard    sb = new();

    msgpack_token_encoder_top dut
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .busy     (busy),
        .func     (func),
        .value    (value),
        .ext_type (ext_type),
        .strobe   (strobe),
        .out_byte (out_byte),
        .last     (last),
        .error    (error)
    );

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        if (rst_n && strobe)
            sb.check_byte(out_byte, last, error);
    end

    task automatic send_token(input logic [3:0] f, input logic [63:0] v, input logic [7:0] t);
        while (idle_on && $urandom_range(0, 99) < 30)
        begin
            start <= 1'b0;
            @(posedge clk);
        end
        start    <= 1'b1;
        func     <= f;
        value    <= v;
        ext_type <= t;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        sb.note_token(f, v, t);
    endtask

    function automatic logic [63:0] pick_operand(logic [3:0] f);
        logic [63:0] v;
        case ($urandom_range(0, 5))
            0:       v = 64'($urandom_range(0, 300));
            1:       v = EDGE_VALUES[$urandom_range(0, 19)] + 64'($urandom_range(0, 2)) - 64'd1;
            2:       v = ~64'($urandom_range(0, 199));
            3:       v = {$urandom, 16'h0000, 16'($urandom)};
            default: v = {$urandom, $urandom};
        endcase
        if (f == mpenc_pkg::FN_EXT && $urandom_range(0, 99) < 40)
            v = {$urandom, 32'd1 << $urandom_range(0, 4)};
        return v;
    endfunction

    initial
    begin
        logic [3:0] f;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_token(mpenc_pkg::FN_NIL,   64'd0, 8'h00);
        send_token(mpenc_pkg::FN_BOOL,  64'hFFFF_FFFF_FFFF_FFFE, 8'h00);
        send_token(mpenc_pkg::FN_BOOL,  64'd1, 8'h00);
        send_token(mpenc_pkg::FN_UINT,  64'd127, 8'h00);
        send_token(mpenc_pkg::FN_UINT,  64'd128, 8'h00);
        send_token(mpenc_pkg::FN_UINT,  64'd65535, 8'h00);
        send_token(mpenc_pkg::FN_UINT,  64'hFFFF_FFFF, 8'h00);
        send_token(mpenc_pkg::FN_UINT,  64'hFFFF_FFFF_FFFF_FFFF, 8'h00);
        send_token(mpenc_pkg::FN_INT,   64'hFFFF_FFFF_FFFF_FFE0, 8'h00);
        send_token(mpenc_pkg::FN_INT,   64'hFFFF_FFFF_FFFF_FFDF, 8'h00);
        send_token(mpenc_pkg::FN_INT,   64'd128, 8'h00);
        send_token(mpenc_pkg::FN_INT,   64'hFFFF_FFFF_FFFF_7FFF, 8'h00);
        send_token(mpenc_pkg::FN_INT,   64'h8000_0000_0000_0000, 8'h00);
        send_token(mpenc_pkg::FN_F32,   64'hDEAD_BEEF_3F80_0000, 8'h00);
        send_token(mpenc_pkg::FN_F64,   64'h7FF8_0000_0000_0001, 8'h00);
        send_token(mpenc_pkg::FN_STR,   64'd31, 8'h00);
        send_token(mpenc_pkg::FN_STR,   64'hFFFF_FFFF_0000_0020, 8'h00);
        send_token(mpenc_pkg::FN_BIN,   64'd0, 8'h00);
        send_token(mpenc_pkg::FN_ARRAY, 64'd16, 8'h00);
        send_token(mpenc_pkg::FN_MAP,   64'd65536, 8'h00);
        send_token(mpenc_pkg::FN_EXT,   64'd16, 8'h80);
        send_token(mpenc_pkg::FN_EXT,   64'd3, 8'h7F);
        send_token(mpenc_pkg::FN_EXT,   64'd65536, 8'h55);
        send_token(mpenc_pkg::FN_RAW,   64'hFFFF_FFFF_FFFF_FF80, 8'h00);
        send_token(FN_UNUSED_LO, 64'hFFFF_FFFF_FFFF_FFFF, 8'hFF);
        send_token(FN_UNUSED_HI, 64'd0, 8'h00);

        for (int n = 0; n < RANDOM_TOKENS; n++)
        begin
            // a burst of back-to-back transfers first
            idle_on = (n >= QUIET_TOKENS);
            if ($urandom_range(0, 99) < 8)
                f = 4'($urandom_range(FN_UNUSED_LO, FN_UNUSED_HI));
            else
                f = 4'($urandom_range(mpenc_pkg::FN_NIL, mpenc_pkg::FN_RAW));
            send_token(f, pick_operand(f), 8'($urandom));
        end
        start <= 1'b0;

        while (sb.pending.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);

        $display("Run covered %0d tokens, %0d of them with unused codes; %0d bytes checked.",
                 sb.tokens, sb.err_tokens, sb.bytes_seen);
        if (sb.mismatches == 0 && sb.pending.size() == 0)
            $display("msgpack_token_encoder_top: match");
        else
            $display("msgpack_token_encoder_top: mismatch");
        $finish;
    end

    initial
    begin
        #500us;
        $display("Timed out with %0d bytes outstanding", sb.pending.size());
        $display("msgpack_token_encoder_top: mismatch");
        $finish;
    end

endmodule
